@@ rtl/srrip_pkg.sv @@
// Shared constants, types and helper functions of the replacement engine.
// No dependencies; srrip_victim and the top level import this package.
`default_nettype none

package srrip_pkg;

  localparam int unsigned NumSetsDef      = 2048;
  localparam int unsigned NumWaysDef      = 16;
  localparam int unsigned ReuseEntriesDef = 4096;

  localparam int unsigned SetW    = 11;
  localparam int unsigned WayW    = 4;
  localparam int unsigned MaskW   = 16;
  localparam int unsigned AddrW   = 64;
  localparam int unsigned HashW   = 12;
  localparam int unsigned HistW   = 8;
  localparam int unsigned CountW  = 24;
  localparam int unsigned InDataW = 160;
  localparam int unsigned OutDataW = 8;

  localparam logic [CountW-1:0] DecayPeriodRst = 24'd100000;

  localparam logic [1:0] RrpvMax  = 2'd3;
  localparam logic [1:0] RrpvLong = 2'd2;
  localparam logic [1:0] RrpvNear = 2'd0;
  localparam logic [1:0] ReuseRst = 2'd1;

  localparam logic OpVictim = 1'b0;
  localparam logic OpUpdate = 1'b1;

  // Reuse table index from the instruction address.
  function automatic logic [HashW-1:0] pc_hash(input logic [AddrW-1:0] pc);
    return pc[11:0] ^ pc[24:13] ^ pc[34:23];
  endfunction

  // Streaming when at least five of the six newest history bits are set.
  function automatic logic hist_streaming(input logic [HistW-1:0] hist);
    logic [2:0] ones;
    ones = 3'd0;
    for (int i = 0; i < 6; i++) begin
      ones = ones + 3'(hist[i]);
    end
    return ones >= 3'd5;
  endfunction

endpackage

`default_nettype wire

@@ rtl/srrip_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing; used for the RRPV rows, set state and reuse counters.
`default_nettype none

module srrip_ram #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [W-1:0]  rdata_o
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/srrip_victim.sv @@
// Victim selection over one RRPV row: lowest invalid way, else lowest way at
// the maximum RRPV after ageing the row. Depends on srrip_pkg.
`default_nettype none

module srrip_victim
  import srrip_pkg::*;
#(
  parameter int unsigned NUM_WAYS = NumWaysDef,
  parameter int unsigned WAY_AW   = $clog2(NUM_WAYS)
) (
  input  wire logic [NUM_WAYS-1:0][1:0] row_i,
  input  wire logic [MaskW-1:0]         valid_mask_i,
  output logic      [WAY_AW-1:0]        way_o,
  output logic                          all_valid_o,
  output logic      [NUM_WAYS-1:0][1:0] aged_o
);

  logic                   found;
  logic [1:0]             top;
  logic [1:0]             lift;
  logic [WAY_AW-1:0]      inv_way;
  logic [WAY_AW-1:0]      max_way;
  logic                   max_found;

  always_comb begin
    found   = 1'b0;
    inv_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      // ways beyond the mask count as valid
      if (w < MaskW) begin
        if (!valid_mask_i[w]) begin
          found   = 1'b1;
          inv_way = WAY_AW'(w);
        end
      end
    end

    top = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (row_i[w] > top) top = row_i[w];
    end
    lift = RrpvMax - top;

    max_found = 1'b0;
    max_way   = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      aged_o[w] = row_i[w] + lift;
      if (aged_o[w] == RrpvMax) begin
        max_found = 1'b1;
        max_way   = WAY_AW'(w);
      end
    end

    all_valid_o = !found;
    way_o       = found ? inv_way : (max_found ? max_way : '0);
  end

endmodule

`default_nettype wire

@@ rtl/rrip_replacement_with_stream_reuse.sv @@
// Replacement engine top level: sequencer, stream detector, reuse counters.
// Depends on srrip_pkg, srrip_ram and srrip_victim.
//
// Input channel s_axis: one item per victim request (tuser = 0) or update
// (tuser = 1). Output channel m_axis: one result item per input item, in
// order: the victim way (zero for updates) and the set's streaming flag.
// An item passes through accept, index reduction and memory read,
// read-modify-write of the RRPV row, set state and reuse counter, then the
// handoff to the output register. Index reduction repeats its subtraction
// while set_index or the PC hash exceed the configured depths.
// Each time the update count reaches the decay period the reuse table is
// swept once, one counter per cycle through its single read and write port;
// no item is accepted during the sweep.
// After reset a clearing pass over max(NUM_SETS, REUSE_ENTRIES) addresses
// writes the reset values into all memories; tready stays low until it ends.
// The output register holds a result while the receiver stalls; the next
// item is still taken and worked on, and waits for the register to drain.
// Decay period: write via cfg_wen_i/cfg_wdata_i only while idle (not enforced).
`default_nettype none

module rrip_replacement_with_stream_reuse
  import srrip_pkg::*;
#(
  parameter int unsigned NUM_SETS      = NumSetsDef,
  parameter int unsigned NUM_WAYS      = NumWaysDef,
  parameter int unsigned REUSE_ENTRIES = ReuseEntriesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_wen_i,
  input  wire logic [CountW-1:0]   cfg_wdata_i,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // set_index[10:0], way_index[14:11], valid_mask[30:15], phys_addr[94:31],
  // prog_counter[158:95], was_hit[159]
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // operation[0]
  input  wire logic                s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // victim_way[3:0], set_streaming[4], zero[7:5]
  output logic [OutDataW-1:0]      m_axis_tdata_o
);

  localparam int unsigned SET_AW  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned RE_AW   = $clog2(REUSE_ENTRIES);
  localparam int unsigned WAY_AW  = $clog2(NUM_WAYS);
  localparam int unsigned ROW_W   = 2 * NUM_WAYS;
  localparam int unsigned SST_W   = HistW + AddrW;
  localparam int unsigned CLR_N   = (NUM_SETS > REUSE_ENTRIES) ? NUM_SETS : REUSE_ENTRIES;
  localparam int unsigned CNT_W   = $clog2(CLR_N) + 1;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_REDUCE, ST_EXEC, ST_SEND, ST_DECAY
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CountW-1:0]   period_q;
  logic [CountW-1:0]   upd_cnt_q, upd_cnt_d;
  logic                decay_q, decay_d;

  // Item registers (payload, no reset)
  logic                op_q;
  logic [SetW-1:0]     set_q;
  logic [WayW-1:0]     way_q;
  logic [MaskW-1:0]    mask_q;
  logic [AddrW-1:0]    addr_q;
  logic [HashW-1:0]    hash_q;
  logic                hit_q;
  logic [WayW-1:0]     res_way_q, res_way_d;
  logic                res_flag_q, res_flag_d;

  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic in_acc;
  logic out_free;
  logic set_big, hash_big;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign set_big  = {6'd0, set_q} >= 17'(NUM_SETS);
  assign hash_big = {5'd0, hash_q} >= 17'(REUSE_ENTRIES);

  // ---------------------------------------------------------------------
  // Memories
  logic               rr_we;
  logic [SET_AW-1:0]  rr_waddr;
  logic [ROW_W-1:0]   rr_wdata;
  logic [ROW_W-1:0]   rr_rdata;
  logic               ss_we;
  logic [SET_AW-1:0]  ss_waddr;
  logic [SST_W-1:0]   ss_wdata;
  logic [SST_W-1:0]   ss_rdata;
  logic               ru_we;
  logic [RE_AW-1:0]   ru_waddr;
  logic [1:0]         ru_wdata;
  logic [RE_AW-1:0]   ru_raddr;
  logic [1:0]         ru_rdata;
  logic [SET_AW-1:0]  set_addr;

  assign set_addr = SET_AW'(set_q);
  assign ru_raddr = (state_q == ST_DECAY) ? cnt_q[RE_AW-1:0] : RE_AW'(hash_q);

  srrip_ram #(.W(ROW_W), .DEPTH(NUM_SETS), .AW(SET_AW)) u_rrpv_ram (
    .clk_i, .we_i(rr_we), .waddr_i(rr_waddr), .wdata_i(rr_wdata),
    .raddr_i(set_addr), .rdata_o(rr_rdata)
  );

  srrip_ram #(.W(SST_W), .DEPTH(NUM_SETS), .AW(SET_AW)) u_set_ram (
    .clk_i, .we_i(ss_we), .waddr_i(ss_waddr), .wdata_i(ss_wdata),
    .raddr_i(set_addr), .rdata_o(ss_rdata)
  );

  srrip_ram #(.W(2), .DEPTH(REUSE_ENTRIES), .AW(RE_AW)) u_reuse_ram (
    .clk_i, .we_i(ru_we), .waddr_i(ru_waddr), .wdata_i(ru_wdata),
    .raddr_i(ru_raddr), .rdata_o(ru_rdata)
  );

  // ---------------------------------------------------------------------
  // Victim path
  logic [NUM_WAYS-1:0][1:0] row;
  logic [NUM_WAYS-1:0][1:0] aged;
  logic [NUM_WAYS-1:0][1:0] row_upd;
  logic [WAY_AW-1:0]        vic_way;
  logic                     all_valid;

  assign row = rr_rdata;

  srrip_victim #(.NUM_WAYS(NUM_WAYS), .WAY_AW(WAY_AW)) u_victim (
    .row_i(row), .valid_mask_i(mask_q), .way_o(vic_way),
    .all_valid_o(all_valid), .aged_o(aged)
  );

  // ---------------------------------------------------------------------
  // Update path
  logic [AddrW-1:0]  prev;
  logic [HistW-1:0]  hist;
  logic [AddrW-1:0]  delta;
  logic              dbit;
  logic [HistW-1:0]  hist_new;
  logic              flag_new;
  logic [1:0]        ctr_new;
  logic [1:0]        slot_val;
  logic [5:0]        way_red;
  logic [CountW-1:0] upd_cnt_inc;

  always_comb begin
    prev     = ss_rdata[AddrW-1:0];
    hist     = ss_rdata[SST_W-1:AddrW];
    delta    = addr_q - prev;
    dbit     = (prev != '0) && (delta[AddrW-1:4] == '0) && (delta[3:0] != 4'd0);
    hist_new = {hist[HistW-2:0], dbit};
    flag_new = hist_streaming(hist_new);

    if (hit_q) ctr_new = (ru_rdata == 2'd3) ? ru_rdata : ru_rdata + 2'd1;
    else       ctr_new = (ru_rdata == 2'd0) ? ru_rdata : ru_rdata - 2'd1;

    if (flag_new)              slot_val = RrpvMax;
    else if (ctr_new >= 2'd2)  slot_val = RrpvNear;
    else                       slot_val = RrpvLong;

    // way_index modulo NUM_WAYS
    way_red = {2'd0, way_q};
    for (int i = 0; i < 8; i++) begin
      if (way_red >= 6'(NUM_WAYS)) way_red = way_red - 6'(NUM_WAYS);
    end

    row_upd = row;
    row_upd[WAY_AW'(way_red)] = slot_val;

    upd_cnt_inc = upd_cnt_q + 24'd1;
  end

  // ---------------------------------------------------------------------
  // Sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    upd_cnt_d  = upd_cnt_q;
    decay_d    = decay_q;
    res_way_d  = res_way_q;
    res_flag_d = res_flag_q;

    rr_we    = 1'b0;
    rr_waddr = set_addr;
    rr_wdata = ROW_W'(aged);
    ss_we    = 1'b0;
    ss_waddr = set_addr;
    ss_wdata = {hist_new, addr_q};
    ru_we    = 1'b0;
    ru_waddr = RE_AW'(hash_q);
    ru_wdata = ctr_new;

    case (state_q)
      ST_CLEAR: begin
        rr_we    = cnt_q < CNT_W'(NUM_SETS);
        rr_waddr = cnt_q[SET_AW-1:0];
        rr_wdata = {NUM_WAYS{RrpvMax}};
        ss_we    = cnt_q < CNT_W'(NUM_SETS);
        ss_waddr = cnt_q[SET_AW-1:0];
        ss_wdata = '0;
        ru_we    = cnt_q < CNT_W'(REUSE_ENTRIES);
        ru_waddr = cnt_q[RE_AW-1:0];
        ru_wdata = ReuseRst;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CLR_N - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) state_d = ST_REDUCE;
      end
      ST_REDUCE: begin
        // reads of the set and reuse entries are issued once both are in range
        if (!set_big && !hash_big) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        cnt_d = '0;
        if (op_q == OpUpdate) begin
          rr_we      = 1'b1;
          rr_wdata   = ROW_W'(row_upd);
          ss_we      = 1'b1;
          ru_we      = 1'b1;
          res_way_d  = '0;
          res_flag_d = flag_new;
          if (upd_cnt_inc >= period_q) begin
            upd_cnt_d = '0;
            decay_d   = 1'b1;
          end else begin
            upd_cnt_d = upd_cnt_inc;
          end
        end else begin
          rr_we      = all_valid;
          res_way_d  = WayW'(vic_way);
          res_flag_d = hist_streaming(hist);
        end
        state_d = ST_SEND;
      end
      ST_SEND: begin
        if (out_free) begin
          state_d = decay_q ? ST_DECAY : ST_IDLE;
          decay_d = 1'b0;
        end
      end
      ST_DECAY: begin
        // read entry cnt, write back entry cnt-1 decremented
        ru_we    = cnt_q != '0;
        ru_waddr = RE_AW'(cnt_q - 1'b1);
        ru_wdata = (ru_rdata == 2'd0) ? ru_rdata : ru_rdata - 2'd1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(REUSE_ENTRIES)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      upd_cnt_q   <= '0;
      decay_q     <= 1'b0;
      period_q    <= DecayPeriodRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      upd_cnt_q <= upd_cnt_d;
      decay_q   <= decay_d;
      if (cfg_wen_i) period_q <= cfg_wdata_i;
      if (state_q == ST_SEND && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_way_q  <= res_way_d;
    res_flag_q <= res_flag_d;
    if (in_acc) begin
      op_q   <= s_axis_tuser_i;
      set_q  <= s_axis_tdata_i[10:0];
      way_q  <= s_axis_tdata_i[14:11];
      mask_q <= s_axis_tdata_i[30:15];
      addr_q <= s_axis_tdata_i[94:31];
      hash_q <= pc_hash(s_axis_tdata_i[158:95]);
      hit_q  <= s_axis_tdata_i[159];
    end else if (state_q == ST_REDUCE) begin
      if (set_big)  set_q  <= set_q - SetW'(NUM_SETS);
      if (hash_big) hash_q <= hash_q - HashW'(REUSE_ENTRIES);
    end
    if (state_q == ST_SEND && out_free) begin
      out_data_q <= {3'd0, res_flag_q, res_way_q};
    end
  end

  // ---------------------------------------------------------------------
  a_acc_reduce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_REDUCE)
    else $error("accepted item did not enter reduction");

  a_exec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |-> (!set_big && !hash_big))
    else $error("memory access with unreduced index");

  a_send_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEND && out_free) |=> out_valid_q)
    else $error("result not loaded into output register");

  a_decay_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECAY) |-> (upd_cnt_q == '0))
    else $error("update count not cleared during decay sweep");

endmodule

`default_nettype wire
